>>> rtl/core/e2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// e2d_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, series divisors and rounding functions used by the
// Euler angle to direction cosine matrix pipeline.
// ---------------------------------------------------------------------------
package e2d_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FIELD_W    = 16;
  localparam int VAL_W      = FRAC_BITS + 2;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int WIDE_W     = PROD_W + 2;
  localparam int Q_W        = 31;
  localparam int QP_W       = 2 * Q_W;
  localparam int SH         = 30 - FRAC_BITS;
  localparam int CELLS      = 5;
  localparam int LANES      = 3;
  localparam int STAGES     = 23;

  localparam logic [Q_W-1:0]  Q_ONE  = Q_W'(64'd1 << 30);
  localparam logic [Q_W-1:0]  Q_HALF = Q_W'(64'd1 << 29);
  localparam logic [31:0]     PI_Q30 = 32'd3373259426;
  localparam logic [31:0]     ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  typedef logic [Q_W-1:0]          q30_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam val_t  V_ONE = VAL_W'(64'd1 << FRAC_BITS);
  localparam wide_t W_ONE = WIDE_W'(64'd1 << FRAC_BITS);
  localparam wide_t W_HALF = WIDE_W'(64'd1 << (FRAC_BITS - 1));

  // Series divisor and its truncated reciprocal (2^32 / d); d of zero holds.
  typedef struct packed {
    logic [6:0]  d;
    logic [31:0] m;
  } div_t;

  // One angle's working set as it travels down the row of cells.
  typedef struct packed {
    q30_t       x;
    q30_t       x2;
    q30_t       ts;
    q30_t       tc;
    logic [1:0] quad;
    logic       swap;
  } lane_t;

  localparam div_t SIN_DIV [CELLS] = '{
    '{7'd72, 32'(64'd4294967296 / 72)},
    '{7'd42, 32'(64'd4294967296 / 42)},
    '{7'd20, 32'(64'd4294967296 / 20)},
    '{7'd6,  32'(64'd4294967296 / 6)},
    '{7'd0,  32'd0}
  };

  localparam div_t COS_DIV [CELLS] = '{
    '{7'd90, 32'(64'd4294967296 / 90)},
    '{7'd56, 32'(64'd4294967296 / 56)},
    '{7'd30, 32'(64'd4294967296 / 30)},
    '{7'd12, 32'(64'd4294967296 / 12)},
    '{7'd2,  32'(64'd4294967296 / 2)}
  };

  // Q30 product rounded half up.
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic [QP_W-1:0] p;
    p = QP_W'(a) * QP_W'(b) + QP_W'(Q_HALF);
    return p[30 +: Q_W];
  endfunction

  // Q30 to FRAC_BITS fraction, rounded half up.
  function automatic val_t q30_to_frac(input q30_t v);
    logic [Q_W:0] w;
    w = {1'b0, v} + (Q_W + 1)'(64'd1 << (SH - 1));
    return VAL_W'(w >> SH);
  endfunction

  // Round half towards plus infinity, then saturate to plus or minus one.
  function automatic val_t finish(input wide_t v);
    wide_t r;
    r = v + W_HALF;
    r = r >>> FRAC_BITS;
    if (r > W_ONE) begin
      r = W_ONE;
    end else if (r < -W_ONE) begin
      r = -W_ONE;
    end
    return VAL_W'(r);
  endfunction

  // Place an entry in its 16-bit field.
  function automatic logic [FIELD_W-1:0] to_field(input val_t v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/e2d_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// e2d_cell: one Horner step of the sine and cosine series
// Computes t = 1 - round(x2 * t) / d for both series over three register
// stages, and hands the lane on to the next cell.
// ---------------------------------------------------------------------------
module e2d_cell import e2d_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  div_t       sin_div,
  input  div_t       cos_div,
  input  lane_t      in_lane,
  output lane_t      out_lane
);

  lane_t a_lane;
  lane_t b_lane;
  q30_t  a_ps;
  q30_t  a_pc;
  q30_t  b_ps;
  q30_t  b_pc;
  q30_t  b_qs;
  q30_t  b_qc;
  logic [62:0] qm_s;
  logic [62:0] qm_c;
  logic [37:0] r_s;
  logic [37:0] r_c;
  q30_t  q_s;
  q30_t  q_c;
  lane_t out_lane_next;

  // Stage a: rounded Q30 products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_lane <= in_lane;
      a_ps   <= mul_q30(in_lane.x2, in_lane.ts);
      a_pc   <= mul_q30(in_lane.x2, in_lane.tc);
    end
  end

  // Stage b: quotient estimate by reciprocal multiplication, low by at most one.
  assign qm_s = 63'(a_ps) * 63'(sin_div.m);
  assign qm_c = 63'(a_pc) * 63'(cos_div.m);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_lane <= a_lane;
      b_ps   <= a_ps;
      b_pc   <= a_pc;
      b_qs   <= qm_s[32 +: Q_W];
      b_qc   <= qm_c[32 +: Q_W];
    end
  end

  // Stage c: one correction step, then subtract from one.
  always_comb begin
    r_s = 38'(b_ps) - 38'(b_qs) * 38'(sin_div.d);
    r_c = 38'(b_pc) - 38'(b_qc) * 38'(cos_div.d);
    q_s = b_qs + Q_W'(r_s >= 38'(sin_div.d));
    q_c = b_qc + Q_W'(r_c >= 38'(cos_div.d));
    out_lane_next    = b_lane;
    out_lane_next.ts = (sin_div.d == '0) ? b_lane.ts : Q_ONE - q_s;
    out_lane_next.tc = (cos_div.d == '0) ? b_lane.tc : Q_ONE - q_c;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_lane <= out_lane_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/euler_angles_to_dcm.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// euler_angles_to_dcm: 3-2-1 direction cosine matrix from Euler angles
// Sine and cosine of roll, pitch and yaw by folded Taylor series through a
// row of Horner cells, followed by the matrix products with rounding and
// saturation to Q2.14.
//
// Channel   Dir  Bus            Contents
// s_axis    in   s_tdata[47:0]  roll, pitch, yaw binary angles
// m_axis    out  m_tdata[143:0] m11 .. m33, Q2.14
//
// One transaction is accepted per cycle unless an output stall has backed up
// to stage 0; each result passes through every stage in order before it is presented.
// The 23 stages are the angle reduction, the squaring, five Horner cells of
// three stages each, the final sine multiply, the sign fix-up and four
// product stages.
// Every stage advances when it is empty or its successor advances, so bubbles
// are squeezed out while the output stalls.
// Reset clears the stage valid flags only; data registers are not reset.
// ---------------------------------------------------------------------------
module euler_angles_to_dcm import e2d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata    // m11, m12, m13, m21, m22, m23, m31, m32, m33
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  lane_t p0 [LANES];
  lane_t p1 [LANES];
  lane_t cl [LANES][CELLS];
  q30_t  p17_sq [LANES];
  q30_t  p17_cq [LANES];
  logic [1:0] p17_quad [LANES];
  logic  p17_swap [LANES];
  val_t  sv [LANES];
  val_t  cv [LANES];

  prod_t r_ctcs, r_ctss, r_spct, r_cpct, r_spst, r_cpst, r_cpss, r_cpcs, r_spss, r_spcs;
  val_t  r_st, r_cs, r_ss;
  val_t  f11, f12, f13, f23, f33, f_spst, f_cpst, f_cs, f_ss;
  prod_t g_cpss, g_cpcs, g_spss, g_spcs;
  prod_t h21, h22, h31, h32, h_cpss, h_cpcs, h_spss, h_spcs;
  val_t  h11, h12, h13, h23, h33;
  val_t  o11, o12, o13, o21, o22, o23, o31, o32, o33;

  // Stage advance: a stage loads when empty or when its successor loads.
  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[STAGES-1];

  // Stage 0: quadrant split, fold to the first octant, scale to Q30 radians.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < LANES; l++) begin
        logic [31:0] turn;
        logic [29:0] r;
        logic [29:0] rf;
        logic [61:0] xp;
        turn = ({16'b0, s_tdata[l*16 +: 16]} & ANGLE_MASK) << (32 - ANGLE_BITS);
        r    = turn[29:0];
        rf   = (r > 30'(Q_HALF)) ? 30'(Q_ONE) - r : r;
        xp   = 62'(rf) * 62'(PI_Q30) + 62'(Q_ONE);
        p0[l].x    <= xp[31 +: Q_W];
        p0[l].x2   <= '0;
        p0[l].ts   <= Q_ONE;
        p0[l].tc   <= Q_ONE;
        p0[l].quad <= turn[31:30];
        p0[l].swap <= r > 30'(Q_HALF);
      end
    end
  end

  // Stage 1: square of the reduced angle.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < LANES; l++) begin
        p1[l] <= '{x: p0[l].x, x2: mul_q30(p0[l].x, p0[l].x), ts: p0[l].ts,
                   tc: p0[l].tc, quad: p0[l].quad, swap: p0[l].swap};
      end
    end
  end

  // Stages 2 to 16: row of Horner cells, one row per angle.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
      e2d_cell u_cell (
        .clk      (clk),
        .en       (rdy[2 + 3*k +: 3]),
        .sin_div  (SIN_DIV[k]),
        .cos_div  (COS_DIV[k]),
        .in_lane  ((k == 0) ? p1[l] : cl[l][(k == 0) ? 0 : k - 1]),
        .out_lane (cl[l][k])
      );
    end
  end

  // Stage 17: final sine multiply.
  always_ff @(posedge clk) begin
    if (rdy[17]) begin
      for (int l = 0; l < LANES; l++) begin
        p17_sq[l]   <= mul_q30(cl[l][CELLS-1].x, cl[l][CELLS-1].ts);
        p17_cq[l]   <= cl[l][CELLS-1].tc;
        p17_quad[l] <= cl[l][CELLS-1].quad;
        p17_swap[l] <= cl[l][CELLS-1].swap;
      end
    end
  end

  // Stage 18: round to FRAC_BITS, undo the fold and apply the quadrant.
  always_ff @(posedge clk) begin
    if (rdy[18]) begin
      for (int l = 0; l < LANES; l++) begin
        val_t s;
        val_t c;
        s = q30_to_frac(p17_swap[l] ? p17_cq[l] : p17_sq[l]);
        c = q30_to_frac(p17_swap[l] ? p17_sq[l] : p17_cq[l]);
        case (p17_quad[l])
          2'd0: begin
            sv[l] <= s;
            cv[l] <= c;
          end
          2'd1: begin
            sv[l] <= c;
            cv[l] <= -s;
          end
          2'd2: begin
            sv[l] <= -s;
            cv[l] <= -c;
          end
          default: begin
            sv[l] <= -c;
            cv[l] <= s;
          end
        endcase
      end
    end
  end

  // Stage 19: pairwise products of the trigonometric terms.
  always_ff @(posedge clk) begin
    if (rdy[19]) begin
      r_ctcs <= cv[1] * cv[2];
      r_ctss <= cv[1] * sv[2];
      r_spct <= sv[0] * cv[1];
      r_cpct <= cv[0] * cv[1];
      r_spst <= sv[0] * sv[1];
      r_cpst <= cv[0] * sv[1];
      r_cpss <= cv[0] * sv[2];
      r_cpcs <= cv[0] * cv[2];
      r_spss <= sv[0] * sv[2];
      r_spcs <= sv[0] * cv[2];
      r_st   <= sv[1];
      r_cs   <= cv[2];
      r_ss   <= sv[2];
    end
  end

  // Stage 20: finish the simple entries and the two triple-product factors.
  always_ff @(posedge clk) begin
    if (rdy[20]) begin
      f11    <= finish(WIDE_W'(r_ctcs));
      f12    <= finish(WIDE_W'(r_ctss));
      f13    <= -r_st;
      f23    <= finish(WIDE_W'(r_spct));
      f33    <= finish(WIDE_W'(r_cpct));
      f_spst <= finish(WIDE_W'(r_spst));
      f_cpst <= finish(WIDE_W'(r_cpst));
      f_cs   <= r_cs;
      f_ss   <= r_ss;
      g_cpss <= r_cpss;
      g_cpcs <= r_cpcs;
      g_spss <= r_spss;
      g_spcs <= r_spcs;
    end
  end

  // Stage 21: triple products.
  always_ff @(posedge clk) begin
    if (rdy[21]) begin
      h21    <= f_spst * f_cs;
      h22    <= f_spst * f_ss;
      h31    <= f_cpst * f_cs;
      h32    <= f_cpst * f_ss;
      h_cpss <= g_cpss;
      h_cpcs <= g_cpcs;
      h_spss <= g_spss;
      h_spcs <= g_spcs;
      h11    <= f11;
      h12    <= f12;
      h13    <= f13;
      h23    <= f23;
      h33    <= f33;
    end
  end

  // Stage 22: output register with the compound entries.
  always_ff @(posedge clk) begin
    if (rdy[22]) begin
      o11 <= h11;
      o12 <= h12;
      o13 <= h13;
      o21 <= finish(WIDE_W'(h21) - WIDE_W'(h_cpss));
      o22 <= finish(WIDE_W'(h22) + WIDE_W'(h_cpcs));
      o23 <= h23;
      o31 <= finish(WIDE_W'(h31) + WIDE_W'(h_spss));
      o32 <= finish(WIDE_W'(h32) - WIDE_W'(h_spcs));
      o33 <= h33;
    end
  end

  assign m_tdata = {to_field(o33), to_field(o32), to_field(o31),
                    to_field(o23), to_field(o22), to_field(o21),
                    to_field(o13), to_field(o12), to_field(o11)};

  // An empty output stage means every stage can load.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with an empty output stage");

  // Nothing is presented in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result presented straight after reset");

  // Saturated entries stay within plus or minus one.
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o11 <= V_ONE && o11 >= -V_ONE && o22 <= V_ONE && o22 >= -V_ONE &&
                  o33 <= V_ONE && o33 >= -V_ONE))
    else $error("diagonal entry out of range");

  a_cross_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o21 <= V_ONE && o21 >= -V_ONE && o32 <= V_ONE && o32 >= -V_ONE))
    else $error("compound entry out of range");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for euler_angles_to_dcm
// Drives roll, pitch and yaw triples into the stream input and checks each
// matrix against a local fixed-point sine, cosine and product predictor, with
// random gaps on both sides.
// ---------------------------------------------------------------------------

class dcm_scoreboard;
  logic [143:0] pending[$];
  int errors;

  // Q30 product rounded half up.
  static function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Sine and cosine of a 16-bit binary angle, 14 fractional bits.
  static function void angle_sin_cos(input logic [15:0] ang, output longint s_o,
                                     output longint c_o);
    logic [31:0] turn;
    logic [1:0] quad;
    longint unsigned r, x, x2, t, sq, cq;
    longint s, c;
    bit swap;
    turn = {ang, 16'd0};
    quad = turn[31:30];
    r = turn[29:0];
    swap = 0;
    if (r > (64'd1 << 29)) begin
      r = (64'd1 << 30) - r;
      swap = 1;
    end
    x = (r * 64'd3373259426 + (64'd1 << 30)) >> 31;
    x2 = q30_mul(x, x);
    t = (64'd1 << 30) - q30_mul(x2, 64'd1 << 30) / 72;
    t = (64'd1 << 30) - q30_mul(x2, t) / 42;
    t = (64'd1 << 30) - q30_mul(x2, t) / 20;
    t = (64'd1 << 30) - q30_mul(x2, t) / 6;
    sq = q30_mul(x, t);
    t = (64'd1 << 30) - q30_mul(x2, 64'd1 << 30) / 90;
    t = (64'd1 << 30) - q30_mul(x2, t) / 56;
    t = (64'd1 << 30) - q30_mul(x2, t) / 30;
    t = (64'd1 << 30) - q30_mul(x2, t) / 12;
    cq = (64'd1 << 30) - q30_mul(x2, t) / 2;
    s = longint'(((swap ? cq : sq) + (64'd1 << 15)) >> 16);
    c = longint'(((swap ? sq : cq) + (64'd1 << 15)) >> 16);
    case (quad)
      2'd0: begin s_o = s; c_o = c; end
      2'd1: begin s_o = c; c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  // Round half towards plus infinity and saturate to plus or minus one.
  static function longint settle(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  static function logic [143:0] dcm_of(logic [47:0] angles);
    longint sp, cp, st, ct, ss, cs, spst, cpst;
    longint e[9];
    logic [143:0] m;
    angle_sin_cos(angles[15:0], sp, cp);
    angle_sin_cos(angles[31:16], st, ct);
    angle_sin_cos(angles[47:32], ss, cs);
    spst = settle(sp * st);
    cpst = settle(cp * st);
    e[0] = settle(ct * cs);
    e[1] = settle(ct * ss);
    e[2] = settle(-st * 16384);
    e[3] = settle(spst * cs - cp * ss);
    e[4] = settle(spst * ss + cp * cs);
    e[5] = settle(sp * ct);
    e[6] = settle(cpst * cs + sp * ss);
    e[7] = settle(cpst * ss - sp * cs);
    e[8] = settle(cp * ct);
    for (int i = 0; i < 9; i++) m[16*i +: 16] = e[i][15:0];
    return m;
  endfunction

  function void note_angles(logic [47:0] angles);
    pending.push_back(dcm_of(angles));
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void check_matrix(logic [143:0] got);
    logic [143:0] want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected matrix %h", got));
      return;
    end
    want = pending.pop_front();
    for (int i = 0; i < 9; i++)
      if (got[16*i +: 16] !== want[16*i +: 16])
        report($sformatf("m%0d%0d got %h want %h", i / 3 + 1, i % 3 + 1,
                         got[16*i +: 16], want[16*i +: 16]));
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [143:0] m_tdata;

  dcm_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned received = 0;

  euler_angles_to_dcm dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Hard time limit on the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure, checking on each transaction.
  initial begin : sink
    int g;
    @(posedge clk iff !rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff m_tvalid);
      sb.check_matrix(m_tdata);
      received++;
    end
  end

  task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                             bit may_idle);
    int g;
    g = may_idle ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yaw, pitch, roll};
    @(posedge clk iff s_tready);
    sb.note_angles({yaw, pitch, roll});
    sent++;
  endtask

  function automatic logic [15:0] rand_angle();
    logic [15:0] special[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                                 16'h7FFF, 16'h8001, 16'hFFFF, 16'h0001, 16'h6000};
    if ($urandom_range(9) == 0) return special[$urandom_range(9)];
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    logic [15:0] dir[12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                             16'h2000, 16'h2001, 16'h1FFF, 16'hFFFF, 16'h0001,
                             16'hAAAA, 16'h5555};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: quadrant edges, octant fold, gimbal-lock pitch and extremes.
    for (int i = 0; i < 12; i++) send_angles(dir[i], dir[i], dir[i], 0);
    send_angles(16'h1234, 16'h4000, 16'h5678, 0);
    send_angles(16'h9ABC, 16'hC000, 16'hDEF0, 0);
    send_angles(16'h8000, 16'h7FFF, 16'h0000, 0);
    send_angles(16'h0000, 16'h8000, 16'h7FFF, 0);
    send_angles(16'h7FFF, 16'h0000, 16'h8000, 0);
    // Random part, with one full drain mid-way and a burst with no idling.
    for (int n = 0; n < 1050; n++) begin
      if (n == 500) begin
        s_tvalid <= 1'b0;
        @(posedge clk iff sb.pending.size() == 0);
      end
      send_angles(rand_angle(), rand_angle(), rand_angle(), !(n >= 700 && n < 800));
    end
    s_tvalid <= 1'b0;
    @(posedge clk iff sb.pending.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d angle triples and checked %0d matrices, with random gaps and stalls.",
             sent, received);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
